/* design/rle8le_pkg.sv */
package rle8le_pkg;

    // literal store size and the widths that follow from it
    localparam int MAX_LITERAL = 32;
    localparam int LIT_CNT_W   = $clog2(MAX_LITERAL + 1);
    localparam int LIT_IDX_W   = $clog2(MAX_LITERAL);

    // command queue between front and back
    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);

    // code bytes
    localparam logic [7:0] RUN_MAX   = 8'hFF;
    localparam logic [7:0] TAG_SHORT = 8'h01;
    localparam logic [7:0] TAG_ESC   = 8'h00;
    localparam logic [7:0] EOL_BYTE  = 8'h00;

    typedef enum logic [1:0] {
        CMD_PAIR,
        CMD_LIT,
        CMD_FLUSH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [7:0]             byte_a;
        logic [7:0]             byte_b;
        logic [LIT_CNT_W-1:0]   lit_cnt;
        logic                   flush;
        logic                   last;
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_END_CLOSE,
        PH_END_FLUSH,
        PH_END_MARK
    } front_phase_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PAIR2,
        BK_HDR,
        BK_LIT_DATA,
        BK_LIT_TAG
    } back_state_t;

endpackage

/* design/rle8le_front.sv */
module rle8le_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          pixel_byte,
    input  logic                line_end,
    output logic                cmd_push,
    output rle8le_pkg::cmd_t    cmd_data,
    input  logic                cmd_full
);

    rle8le_pkg::front_phase_t phase_reg, phase_next;

    logic [7:0]                         held_reg, held_next;
    logic                               have_reg, have_next;
    logic [7:0]                         count_reg, count_next;
    logic [rle8le_pkg::LIT_CNT_W-1:0]   fill_reg, fill_next;

    logic                               accept;
    logic                               equal;
    logic [7:0]                         cnt_inc;
    logic [rle8le_pkg::LIT_CNT_W-1:0]   fill_inc;
    logic                               lit_full;
    rle8le_pkg::cmd_t                   close_cmd;
    logic [rle8le_pkg::LIT_CNT_W-1:0]   close_fill;

    assign full     = (phase_reg != rle8le_pkg::PH_IDLE) || cmd_full;
    assign accept   = push && !full;
    assign equal    = have_reg && (pixel_byte == held_reg);
    assign cnt_inc  = count_reg + 8'd1;
    assign fill_inc = fill_reg + rle8le_pkg::LIT_CNT_W'(1);
    assign lit_full = (fill_inc == rle8le_pkg::LIT_CNT_W'(rle8le_pkg::MAX_LITERAL));

    // closing the held run: a pair for a real run, else one more literal
    always_comb
    begin
        close_cmd.kind    = rle8le_pkg::CMD_PAIR;
        close_cmd.byte_a  = count_reg;
        close_cmd.byte_b  = held_reg;
        close_cmd.lit_cnt = fill_inc;
        close_cmd.flush   = 1'b0;
        close_cmd.last    = 1'b0;
        close_fill        = fill_reg;
        if (count_reg < 8'd2)
        begin
            close_cmd.kind   = rle8le_pkg::CMD_LIT;
            close_cmd.byte_a = held_reg;
            close_cmd.flush  = lit_full;
            close_fill       = lit_full ? '0 : fill_inc;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            rle8le_pkg::PH_IDLE:
            begin
                if (accept && line_end)
                begin
                    phase_next = rle8le_pkg::PH_END_CLOSE;
                end
            end
            rle8le_pkg::PH_END_CLOSE:
            begin
                if (!cmd_full)
                begin
                    phase_next = rle8le_pkg::PH_END_FLUSH;
                end
            end
            rle8le_pkg::PH_END_FLUSH:
            begin
                if (!cmd_full)
                begin
                    phase_next = rle8le_pkg::PH_END_MARK;
                end
            end
            rle8le_pkg::PH_END_MARK:
            begin
                if (!cmd_full)
                begin
                    phase_next = rle8le_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = rle8le_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        held_next        = held_reg;
        have_next        = have_reg;
        count_next       = count_reg;
        fill_next        = fill_reg;
        cmd_push         = 1'b0;
        cmd_data.kind    = rle8le_pkg::CMD_PAIR;
        cmd_data.byte_a  = rle8le_pkg::EOL_BYTE;
        cmd_data.byte_b  = rle8le_pkg::EOL_BYTE;
        cmd_data.lit_cnt = fill_reg;
        cmd_data.flush   = 1'b0;
        cmd_data.last    = 1'b0;
        case (phase_reg)
            rle8le_pkg::PH_IDLE:
            begin
                if (accept)
                begin
                    if (equal)
                    begin
                        count_next = cnt_inc;
                        // second equal byte: pending literals go first
                        if (cnt_inc == 8'd2 && fill_reg != '0)
                        begin
                            cmd_push         = 1'b1;
                            cmd_data.kind    = rle8le_pkg::CMD_FLUSH;
                            cmd_data.lit_cnt = fill_reg;
                            cmd_data.last    = !line_end;
                            fill_next        = '0;
                        end
                        // saturated run goes out at once
                        if (cnt_inc == rle8le_pkg::RUN_MAX)
                        begin
                            cmd_push        = 1'b1;
                            cmd_data.kind   = rle8le_pkg::CMD_PAIR;
                            cmd_data.byte_a = rle8le_pkg::RUN_MAX;
                            cmd_data.byte_b = held_reg;
                            cmd_data.last   = !line_end;
                            have_next       = 1'b0;
                            count_next      = 8'd0;
                        end
                    end
                    else
                    begin
                        if (have_reg)
                        begin
                            cmd_push      = 1'b1;
                            cmd_data      = close_cmd;
                            cmd_data.last = !line_end;
                            fill_next     = close_fill;
                        end
                        held_next  = pixel_byte;
                        have_next  = 1'b1;
                        count_next = 8'd1;
                    end
                end
            end
            rle8le_pkg::PH_END_CLOSE:
            begin
                if (!cmd_full && have_reg)
                begin
                    cmd_push   = 1'b1;
                    cmd_data   = close_cmd;
                    fill_next  = close_fill;
                    have_next  = 1'b0;
                    count_next = 8'd0;
                end
            end
            rle8le_pkg::PH_END_FLUSH:
            begin
                if (!cmd_full && fill_reg != '0)
                begin
                    cmd_push         = 1'b1;
                    cmd_data.kind    = rle8le_pkg::CMD_FLUSH;
                    cmd_data.lit_cnt = fill_reg;
                    fill_next        = '0;
                end
            end
            rle8le_pkg::PH_END_MARK:
            begin
                if (!cmd_full)
                begin
                    cmd_push      = 1'b1;
                    cmd_data.last = 1'b1;
                    held_next     = 8'd0;
                end
            end
            default:
            begin
                cmd_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rle8le_pkg::PH_IDLE;
            held_reg  <= 8'd0;
            have_reg  <= 1'b0;
            count_reg <= 8'd0;
            fill_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            have_reg  <= have_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

/* design/rle8le_cmd_fifo.sv */
module rle8le_cmd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  rle8le_pkg::cmd_t    wr_data,
    output logic                full,
    input  logic                rd_en,
    output rle8le_pkg::cmd_t    rd_data,
    output logic                valid
);

    rle8le_pkg::cmd_t                   slot_reg [rle8le_pkg::CQ_DEPTH];
    logic [rle8le_pkg::CQ_PTR_W-1:0]    wr_ptr_reg;
    logic [rle8le_pkg::CQ_PTR_W-1:0]    rd_ptr_reg;
    logic [rle8le_pkg::CQ_PTR_W:0]      cnt_reg;
    logic                               do_wr;
    logic                               do_rd;

    assign full    = (cnt_reg == (rle8le_pkg::CQ_PTR_W + 1)'(rle8le_pkg::CQ_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + rle8le_pkg::CQ_PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + rle8le_pkg::CQ_PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + (rle8le_pkg::CQ_PTR_W + 1)'(1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - (rle8le_pkg::CQ_PTR_W + 1)'(1);
            end
        end
    end

endmodule

/* design/rle8le_back.sv */
module rle8le_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  rle8le_pkg::cmd_t    cmd_data,
    output logic                cmd_pop,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          code_byte,
    output logic                final_of_burst
);

    rle8le_pkg::back_state_t state_reg, state_next;

    logic [7:0]                         lit_mem [rle8le_pkg::MAX_LITERAL];
    logic [7:0]                         mem_q_reg;
    logic                               mem_we;
    logic [rle8le_pkg::LIT_IDX_W-1:0]   mem_waddr;

    logic [7:0]                         byte_b_reg, byte_b_next;
    logic                               last_reg, last_next;
    logic [rle8le_pkg::LIT_CNT_W-1:0]   n_reg, n_next;
    logic [rle8le_pkg::LIT_IDX_W-1:0]   idx_reg, idx_next;

    logic                               out_valid_reg;
    logic [7:0]                         out_byte_reg;
    logic                               out_final_reg;

    logic                               out_ready;
    logic                               emit;
    logic [7:0]                         emit_byte;
    logic                               emit_final;
    logic                               start_short;
    logic                               short_mode;
    logic                               lit_last;

    assign out_ready      = !out_valid_reg || pop;
    assign empty          = !out_valid_reg;
    assign code_byte      = out_byte_reg;
    assign final_of_burst = out_final_reg;

    assign start_short = (cmd_data.lit_cnt <= rle8le_pkg::LIT_CNT_W'(2));
    assign short_mode  = (n_reg <= rle8le_pkg::LIT_CNT_W'(2));
    assign lit_last    = ((rle8le_pkg::LIT_CNT_W'(idx_reg) + rle8le_pkg::LIT_CNT_W'(1))
                          == n_reg);
    assign mem_waddr   = rle8le_pkg::LIT_IDX_W'(cmd_data.lit_cnt
                                                - rle8le_pkg::LIT_CNT_W'(1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rle8le_pkg::BK_IDLE:
            begin
                if (cmd_valid && out_ready)
                begin
                    case (cmd_data.kind)
                        rle8le_pkg::CMD_PAIR:
                        begin
                            state_next = rle8le_pkg::BK_PAIR2;
                        end
                        rle8le_pkg::CMD_LIT:
                        begin
                            if (cmd_data.flush)
                            begin
                                state_next = start_short ? rle8le_pkg::BK_LIT_DATA
                                                         : rle8le_pkg::BK_HDR;
                            end
                        end
                        rle8le_pkg::CMD_FLUSH:
                        begin
                            state_next = start_short ? rle8le_pkg::BK_LIT_DATA
                                                     : rle8le_pkg::BK_HDR;
                        end
                        default:
                        begin
                            state_next = rle8le_pkg::BK_IDLE;
                        end
                    endcase
                end
            end
            rle8le_pkg::BK_PAIR2:
            begin
                if (out_ready)
                begin
                    state_next = rle8le_pkg::BK_IDLE;
                end
            end
            rle8le_pkg::BK_HDR:
            begin
                if (out_ready)
                begin
                    state_next = rle8le_pkg::BK_LIT_DATA;
                end
            end
            rle8le_pkg::BK_LIT_DATA:
            begin
                if (out_ready)
                begin
                    if (lit_last)
                    begin
                        state_next = rle8le_pkg::BK_IDLE;
                    end
                    else if (short_mode)
                    begin
                        state_next = rle8le_pkg::BK_LIT_TAG;
                    end
                end
            end
            rle8le_pkg::BK_LIT_TAG:
            begin
                if (out_ready)
                begin
                    state_next = rle8le_pkg::BK_LIT_DATA;
                end
            end
            default:
            begin
                state_next = rle8le_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop     = 1'b0;
        mem_we      = 1'b0;
        emit        = 1'b0;
        emit_byte   = rle8le_pkg::TAG_ESC;
        emit_final  = 1'b0;
        byte_b_next = byte_b_reg;
        last_next   = last_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        case (state_reg)
            rle8le_pkg::BK_IDLE:
            begin
                idx_next = '0;
                if (cmd_valid && out_ready)
                begin
                    cmd_pop     = 1'b1;
                    byte_b_next = cmd_data.byte_b;
                    last_next   = cmd_data.last;
                    n_next      = cmd_data.lit_cnt;
                    case (cmd_data.kind)
                        rle8le_pkg::CMD_PAIR:
                        begin
                            emit      = 1'b1;
                            emit_byte = cmd_data.byte_a;
                        end
                        rle8le_pkg::CMD_LIT:
                        begin
                            mem_we = 1'b1;
                            if (cmd_data.flush)
                            begin
                                emit      = 1'b1;
                                emit_byte = start_short ? rle8le_pkg::TAG_SHORT
                                                        : rle8le_pkg::TAG_ESC;
                            end
                        end
                        rle8le_pkg::CMD_FLUSH:
                        begin
                            emit      = 1'b1;
                            emit_byte = start_short ? rle8le_pkg::TAG_SHORT
                                                    : rle8le_pkg::TAG_ESC;
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            rle8le_pkg::BK_PAIR2:
            begin
                if (out_ready)
                begin
                    emit       = 1'b1;
                    emit_byte  = byte_b_reg;
                    emit_final = last_reg;
                end
            end
            rle8le_pkg::BK_HDR:
            begin
                if (out_ready)
                begin
                    emit      = 1'b1;
                    emit_byte = 8'(n_reg);
                end
            end
            rle8le_pkg::BK_LIT_DATA:
            begin
                if (out_ready)
                begin
                    emit       = 1'b1;
                    emit_byte  = mem_q_reg;
                    emit_final = last_reg && lit_last;
                    idx_next   = lit_last ? '0 : idx_reg + rle8le_pkg::LIT_IDX_W'(1);
                end
            end
            rle8le_pkg::BK_LIT_TAG:
            begin
                if (out_ready)
                begin
                    emit      = 1'b1;
                    emit_byte = rle8le_pkg::TAG_SHORT;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // literal store, with a registered read from the next index, ahead of the byte that needs it
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lit_mem[mem_waddr] <= cmd_data.byte_a;
        end
        mem_q_reg <= lit_mem[idx_next];
    end

    always_ff @(posedge clk)
    begin
        byte_b_reg <= byte_b_next;
        last_reg   <= last_next;
        n_reg      <= n_next;
        if (emit)
        begin
            out_byte_reg  <= emit_byte;
            out_final_reg <= emit_final;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rle8le_pkg::BK_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* design/rle8_line_encoder_top.sv */
// rle8 line encoder: compresses one image line, one byte per input beat, into an
// rle8-style stream. runs of two or more equal bytes come out as (count, value),
// a run reaching 255 is sent at once as (ff, value) and restarts; single bytes
// collect as literals (up to MAX_LITERAL) and leave as (01, byte) pairs when one or
// two are pending, else as 00, n, bytes. a beat with line_end set closes the line
// with 00 00. final_of_burst marks the last output beat caused by an input beat;
// a beat may cause none. a byte without line_end is taken whenever the
// four-entry command queue has room; a line_end beat keeps full high while the
// front closes the run, flushes the literals and posts the end mark. the back
// emits at most one code byte per cycle, when pop keeps up: a pair is two bytes,
// a long literal block n + 2 and one or two literals 2n, so the sustained rate
// is set by the output byte count. after reset the block is ready at once, the
// literal store needs no clearing.
module rle8_line_encoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  pixel_byte,
    input  logic        line_end,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  code_byte,
    output logic        final_of_burst
);

    // front to queue
    logic               fq_push;
    rle8le_pkg::cmd_t   fq_data;
    logic               fq_full;

    // queue to back
    logic               qb_valid;
    rle8le_pkg::cmd_t   qb_data;
    logic               qb_pop;

    // front: run tracking, literal counting, command issue
    rle8le_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel_byte (pixel_byte),
        .line_end   (line_end),
        .cmd_push   (fq_push),
        .cmd_data   (fq_data),
        .cmd_full   (fq_full)
    );

    // short command queue decoupling the two sides
    rle8le_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_data (fq_data),
        .full    (fq_full),
        .rd_en   (qb_pop),
        .rd_data (qb_data),
        .valid   (qb_valid)
    );

    // back: literal store and byte sequencing into the output register
    rle8le_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (qb_valid),
        .cmd_data       (qb_data),
        .cmd_pop        (qb_pop),
        .empty          (empty),
        .pop            (pop),
        .code_byte      (code_byte),
        .final_of_burst (final_of_burst)
    );

endmodule

/* design/rle8le_chk.sv */
module rle8le_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  pixel_byte,
    input  logic        line_end,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  code_byte,
    input  logic        final_of_burst
);

    // a waiting output beat holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(code_byte) && $stable(final_of_burst))
        else $error("output beat changed while stalled");

    // line end keeps the input closed while the line is closed out
    a_eol_busy: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full && line_end |=> full ##1 full ##1 full)
        else $error("input reopened too early after line end");

    // nothing to deliver while in reset
    a_rst_empty: assert property (@(posedge clk)
        !rst_n |-> empty)
        else $error("output not empty during reset");

endmodule

bind rle8_line_encoder_top rle8le_chk u_chk (.*);
